### design/ppsd_pkg.sv
// shared types and constants for the parallel-port sound fifo dac
// no dependencies

package ppsd_pkg;

   // request codes of the input word
   typedef enum logic [2:0] {
      REQ_DATA        = 3'd0,
      REQ_CTRL        = 3'd1,
      REQ_STATUS      = 3'd2,
      REQ_FIFO_TICK   = 3'd3,
      REQ_SAMPLE_TICK = 3'd4
   } req_code_type;

   // sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_POP  = 1'b1
   } seq_state_type;

   // configuration register indexes
   localparam logic REG_FIFO_MODE = 1'b0;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned SAMPLE_W   = 13;
   localparam int unsigned STROBE_BIT = 3;
   localparam logic [BYTE_W-1:0] STATUS_FULL = 8'h40;

   // fifo commands from the sequencer
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [BYTE_W-1:0] push_data;
   } fifo_cmd_type;

   // fifo flags back to the sequencer
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

### design/parallel_port_sound_fifo_dac_core.sv
// top level of the parallel-port sound fifo dac
// depends on ppsd_pkg and ppsd_fifo
//
// Usage
//   req channel: one word per bus access or tick (req_type, req_write_byte).
//   rsp channel: one word per request word, in order: rsp_status_byte,
//     rsp_sample_out and rsp_output_level (dac level after the request).
//   csr port: apb-style, register 0 bit 0 is fifo_mode, to be written by the
//     user only while idle; the block itself does not enforce this.
// Timing and throughput
//   a result is registered in the cycle after its request is taken, but a
//   popping fifo tick first waits in ST_POP for the registered ram read, with
//   req_ready low; otherwise one request is taken per cycle, barring a stall.
// Reset
//   synchronous, active high: levels, latch, control byte, pointers and
//   fill count clear; ram contents are left as they are (never read unwritten).
// Stalls
//   while rsp_valid is held and rsp_ready is low, req_ready stays low; the
//   next request is taken in the same cycle the waiting result is taken.

module parallel_port_sound_fifo_dac_core
   import ppsd_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_type,
   input  logic [BYTE_W-1:0]          req_write_byte,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [BYTE_W-1:0]          rsp_status_byte,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic [BYTE_W-1:0]          rsp_output_level,
   // configuration port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [2:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   seq_state_type state_ff, state_in;

   logic                fifo_mode_ff, fifo_mode_in;
   logic [BYTE_W-1:0]   level_ff, level_in;
   logic [BYTE_W-1:0]   latch_ff, latch_in;
   logic [BYTE_W-1:0]   control_ff, control_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   status_ff, status_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;

   fifo_cmd_type        fifo_cmd;
   fifo_status_type     fifo_status;
   logic [BYTE_W-1:0]   fifo_rd_data;
   logic                accept;
   logic                strobe_fall;
   logic                csr_write;
   req_code_type        req_code;

   assign req_code = req_code_type'(req_type);

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign fifo_mode_in = (csr_write && csr_paddr[2] == REG_FIFO_MODE)
                         ? csr_pwdata[0] : fifo_mode_ff;
   assign csr_prdata = (csr_paddr[2] == REG_FIFO_MODE) ? {31'd0, fifo_mode_ff} : 32'd0;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_code == REQ_FIFO_TICK && !fifo_status.empty) begin
               state_in = ST_POP;
            end
         end
         ST_POP:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = !rsp_valid_ff || rsp_ready;
         ST_POP:  req_ready = 1'b0;
         default: req_ready = 1'b0;
      endcase
   end

   assign accept      = req_valid && req_ready;
   assign strobe_fall = control_ff[STROBE_BIT] && !req_write_byte[STROBE_BIT];

   // fifo commands
   always_comb begin
      fifo_cmd.push      = accept && req_code == REQ_CTRL && strobe_fall;
      fifo_cmd.pop       = accept && req_code == REQ_FIFO_TICK;
      fifo_cmd.push_data = latch_ff;
   end

   // request processing and result word
   always_comb begin
      level_in     = level_ff;
      latch_in     = latch_ff;
      control_in   = control_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      sample_in    = sample_ff;
      if (state_ff == ST_POP) begin
         level_in     = fifo_rd_data;
         rsp_valid_in = 1'b1;
         status_in    = '0;
         sample_in    = '0;
      end else if (accept) begin
         status_in = '0;
         sample_in = '0;
         case (req_code)
            REQ_DATA: begin
               if (fifo_mode_ff) begin
                  latch_in = req_write_byte;
               end else begin
                  level_in = req_write_byte;
               end
            end
            REQ_CTRL:    control_in = req_write_byte;
            REQ_STATUS:  status_in  = fifo_status.full ? STATUS_FULL : '0;
            // (level - mid) * gain, mid flips the top bit
            REQ_SAMPLE_TICK: sample_in = {~level_ff[BYTE_W-1], level_ff[BYTE_W-2:0], 5'd0};
            default: ;
         endcase
         // a popping tick delivers its word from the pop cycle
         rsp_valid_in = !(req_code == REQ_FIFO_TICK && !fifo_status.empty);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fifo_mode_ff <= 1'b0;
         level_ff     <= '0;
         latch_ff     <= '0;
         control_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fifo_mode_ff <= fifo_mode_in;
         level_ff     <= level_in;
         latch_ff     <= latch_in;
         control_ff   <= control_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      sample_ff <= sample_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status_byte  = status_ff;
   assign rsp_sample_out   = $signed(sample_ff);
   assign rsp_output_level = level_ff;

   // sample fifo
   ppsd_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .cmd     (fifo_cmd),
      .status  (fifo_status),
      .rd_data (fifo_rd_data)
   );

endmodule

### design/ppsd_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module ppsd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ppsd_fifo.sv
// sample fifo: pointers, fill count and the backing ram
// depends on ppsd_pkg and ppsd_ram

module ppsd_fifo
   import ppsd_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  fifo_cmd_type      cmd,
   output fifo_status_type   status,
   output logic [BYTE_W-1:0] rd_data
);

   localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // flags
   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);

   assign do_push = cmd.push && !status.full;
   assign do_pop  = cmd.pop && !status.empty;

   // pointer and count update with wrap at the last entry
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // backing store, always reading the head entry
   ppsd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_ptr_ff),
      .wr_data (cmd.push_data),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

endmodule

### verif/parallel_port_sound_fifo_dac_core_tb.sv
// self-checking testbench for parallel_port_sound_fifo_dac_core
// depends on ppsd_pkg and the design files; holds its own model of the dac and fifo
`timescale 1ns / 1ps

module parallel_port_sound_fifo_dac_core_tb
   import ppsd_pkg::*;
;

   localparam int unsigned DEPTH       = 16;
   localparam int          LEVEL_MID   = 128;
   localparam int          SAMPLE_GAIN = 32;
   // request codes with no meaning; the block must leave its state alone
   localparam logic [2:0]  REQ_SPARE_5 = 3'd5;
   localparam logic [2:0]  REQ_SPARE_6 = 3'd6;
   localparam logic [2:0]  REQ_SPARE_7 = 3'd7;
   localparam logic [BYTE_W-1:0] STROBE_MASK = 8'(1 << STROBE_BIT);

   // one predicted result word
   typedef struct {
      logic [BYTE_W-1:0]          status;
      logic signed [SAMPLE_W-1:0] sample;
      logic [BYTE_W-1:0]          level;
   } dac_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [2:0]                 req_type = '0;
   logic [BYTE_W-1:0]          req_write_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [BYTE_W-1:0]          rsp_status_byte;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic [BYTE_W-1:0]          rsp_output_level;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [2:0]                 csr_paddr = '0;
   logic [31:0]                csr_pwdata = '0;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;

   // model state of the dac
   logic              model_fifo_mode = 1'b0;
   logic [BYTE_W-1:0] model_level = '0;
   logic [BYTE_W-1:0] model_latch = '0;
   logic [BYTE_W-1:0] model_ctrl = '0;
   logic [BYTE_W-1:0] model_store [DEPTH];
   int unsigned       model_rd = 0;
   int unsigned       model_wr = 0;
   int unsigned       model_fill = 0;

   dac_word_type pending_dac_words [$];
   int        error_count = 0;
   int        words_sent = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        stall_request = 0;

   parallel_port_sound_fifo_dac_core #(.FIFO_DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_write_byte   (req_write_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_output_level (rsp_output_level),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model of one accepted request word; queues the word the block should return
   task automatic predict_dac_response(input logic [2:0] code, input logic [BYTE_W-1:0] data);
      dac_word_type w;
      int        s;
      w.status = '0;
      w.sample = '0;
      case (code)
         REQ_DATA: begin
            if (model_fifo_mode) model_latch = data;
            else model_level = data;
         end
         REQ_CTRL: begin
            // falling strobe pushes the latch unless the fifo is full
            if (model_ctrl[STROBE_BIT] && !data[STROBE_BIT] && model_fill < DEPTH) begin
               model_store[model_wr] = model_latch;
               model_wr = (model_wr + 1) % DEPTH;
               model_fill++;
            end
            model_ctrl = data;
         end
         REQ_STATUS: begin
            if (model_fill >= DEPTH) w.status = STATUS_FULL;
         end
         REQ_FIFO_TICK: begin
            if (model_fill > 0) begin
               model_level = model_store[model_rd];
               model_rd = (model_rd + 1) % DEPTH;
               model_fill--;
            end
         end
         REQ_SAMPLE_TICK: begin
            s = (int'(model_level) - LEVEL_MID) * SAMPLE_GAIN;
            w.sample = s[SAMPLE_W-1:0];
         end
         default: ;
      endcase
      w.level = model_level;
      pending_dac_words.push_back(w);
   endtask

   // offer one request word, with a random idle gap first
   task automatic send_word(input logic [2:0] code, input logic [BYTE_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= code;
      req_write_byte <= data;
      do @(posedge clock); while (!req_ready);
      predict_dac_response(code, data);
      words_sent++;
   endtask

   // stop offering and wait for every predicted word to come back
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_dac_words.size() != 0) @(posedge clock);
   endtask

   // write fifo_mode over the csr port, then read it back
   task automatic csr_set_fifo_mode(input logic mode);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_FIFO_MODE, 2'b00};
      csr_pwdata  <= {$urandom() & 32'hFFFF_FFFE} | 32'(mode);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      model_fifo_mode = mode;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== 32'(mode)) begin
         $display("%0t: fifo_mode readback expected %h actual %h", $time, 32'(mode), csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one push: load latch, raise strobe, drop strobe
   task automatic push_sequence(input logic [BYTE_W-1:0] data);
      send_word(REQ_DATA, data);
      send_word(REQ_CTRL, 8'($urandom()) | STROBE_MASK);
      send_word(REQ_CTRL, 8'($urandom()) & ~STROBE_MASK);
   endtask

   // result side: check accepted words, then choose ready for the next edge
   always @(posedge clock) begin
      dac_word_type w;
      int        stall_left;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dac_words.size() == 0) begin
            $display("%0t: unexpected word status %h sample %h level %h", $time,
                     rsp_status_byte, rsp_sample_out, rsp_output_level);
            error_count++;
         end else begin
            w = pending_dac_words.pop_front();
            if (rsp_status_byte !== w.status) begin
               $display("%0t: status_byte expected %h actual %h", $time, w.status,
                        rsp_status_byte);
               error_count++;
            end
            if (rsp_sample_out !== w.sample) begin
               $display("%0t: sample_out expected %0d actual %0d", $time, w.sample,
                        rsp_sample_out);
               error_count++;
            end
            if (rsp_output_level !== w.level) begin
               $display("%0t: output_level expected %h actual %h", $time, w.level,
                        rsp_output_level);
               error_count++;
            end
         end
      end
      // long hold-off when a test asks for one
      if (stall_request > 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // extremes of level and sample, spare codes, empty pop, pushes in both modes
   task automatic test_directed();
      send_word(REQ_SAMPLE_TICK, 8'h00);
      send_word(REQ_DATA, 8'hFF);
      send_word(REQ_SAMPLE_TICK, 8'h00);
      send_word(REQ_DATA, 8'h80);
      send_word(REQ_SAMPLE_TICK, 8'hFF);
      send_word(REQ_STATUS, 8'hFF);
      send_word(REQ_SPARE_5, 8'h00);
      send_word(REQ_SPARE_6, 8'hFF);
      send_word(REQ_SPARE_7, 8'h5A);
      send_word(REQ_FIFO_TICK, 8'hFF);
      // strobe edge in direct mode still pushes the latch
      send_word(REQ_CTRL, STROBE_MASK);
      send_word(REQ_CTRL, ~STROBE_MASK);
      send_word(REQ_STATUS, 8'h00);
      send_word(REQ_FIFO_TICK, 8'h00);
      send_word(REQ_SAMPLE_TICK, 8'h00);
      settle_block();
      csr_set_fifo_mode(1'b1);
      send_word(REQ_DATA, 8'hA5);
      send_word(REQ_CTRL, 8'hFF);
      send_word(REQ_CTRL, 8'h00);
      send_word(REQ_CTRL, 8'h00);
      send_word(REQ_FIFO_TICK, 8'h00);
      send_word(REQ_FIFO_TICK, 8'h00);
      send_word(REQ_DATA, 8'h5A);
      send_word(REQ_SAMPLE_TICK, 8'h00);
      settle_block();
   endtask

   // fill past full, drain past empty, twice so the pointers wrap
   task automatic test_fifo_full();
      repeat (2) begin
         repeat (DEPTH + 1) push_sequence(8'($urandom()));
         send_word(REQ_STATUS, 8'($urandom()));
         repeat (DEPTH + 1) begin
            send_word(REQ_FIFO_TICK, 8'($urandom()));
            send_word(REQ_SAMPLE_TICK, 8'($urandom()));
         end
         send_word(REQ_STATUS, 8'($urandom()));
      end
      settle_block();
   endtask

   // mostly push and pop sequences with random content, plus noise
   task automatic test_random_traffic(input int n_items);
      int first;
      int r;
      int push_w;
      int pop_w;
      bit lean_fill;
      first     = words_sent;
      lean_fill = $urandom_range(1);
      while (words_sent - first < n_items) begin
         if ($urandom_range(19) == 0) lean_fill = ~lean_fill;
         push_w = lean_fill ? 50 : 15;
         pop_w  = lean_fill ? 20 : 45;
         r      = $urandom_range(99);
         if (r < push_w) begin
            push_sequence(8'($urandom()));
         end else if (r < push_w + pop_w) begin
            repeat ($urandom_range(1, 4)) send_word(REQ_FIFO_TICK, 8'($urandom()));
            send_word(REQ_SAMPLE_TICK, 8'($urandom()));
         end else if (r < push_w + pop_w + 8) begin
            send_word(REQ_STATUS, 8'($urandom()));
         end else if (r < push_w + pop_w + 13) begin
            send_word(REQ_SAMPLE_TICK, 8'($urandom()));
         end else if (r < push_w + pop_w + 20) begin
            send_word(REQ_DATA, 8'($urandom()));
         end else begin
            send_word(3'($urandom_range(7)), 8'($urandom()));
         end
      end
      settle_block();
   endtask

   // receiver holds off while words keep coming, so the input stalls
   task automatic test_backpressure();
      int saved_send;
      saved_send    = send_idle_pct;
      send_idle_pct = 0;
      stall_request = 200;
      repeat (20) push_sequence(8'($urandom()));
      repeat (10) send_word(REQ_FIFO_TICK, 8'($urandom()));
      send_idle_pct = saved_send;
      settle_block();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fifo_full();
      // three idling regimes, each over both fifo modes
      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin send_idle_pct = 29; recv_idle_pct = 48; end
            1: begin send_idle_pct = 48; recv_idle_pct = 29; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            csr_set_fifo_mode(1'((seg + regime) % 2));
            test_random_traffic(160);
         end
         if (regime == 0) test_backpressure();
      end
      settle_block();
      repeat (4) @(posedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

endmodule
